@@ sv/gap_buffer_edit_store_macros.svh @@
// Assertion macros for the gap buffer edit store checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef GAP_BUFFER_EDIT_STORE_MACROS_SVH
`define GAP_BUFFER_EDIT_STORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define GBES_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gbes: same-cycle check failed");

// Next-cycle implication, off during reset.
`define GBES_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gbes: next-cycle check failed");

// Same-cycle implication that also holds through reset.
`define GBES_ASSERT_ALW(name, ck, ante, cons) \
  name: assert property (@(posedge ck) (ante) |-> (cons)) \
    else $error("gbes: reset check failed");

`endif

@@ sv/gbes_pkg.sv @@
// Shared types and constants for the gap buffer edit store.
// No dependencies; used by the interfaces, the top level and the checker.
package gbes_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int ITEM_BITS_DEF = 8;

  localparam int OP_W     = 2;
  localparam int POS_W    = 11;
  localparam int ITEM_W   = 8;
  localparam int CNT_W    = 11;
  localparam int RDATA_W  = 8;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

@@ sv/gbes_cmd_if.sv @@
// Command channel of the gap buffer edit store: valid/ready plus operation word.
// Depends on gbes_pkg.
interface gbes_cmd_if;
  import gbes_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item;
  logic [CNT_W-1:0]  count;

  modport source(output valid, op, position, item, count, input ready);
  modport sink(input valid, op, position, item, count, output ready);
endinterface

@@ sv/gbes_rsp_if.sv @@
// Response channel of the gap buffer edit store: valid/ready plus result word.
// Depends on gbes_pkg.
interface gbes_rsp_if;
  import gbes_pkg::*;

  logic                valid;
  logic                ready;
  logic [RDATA_W-1:0]  read_data;
  logic [LEN_W-1:0]    length;
  logic [STATUS_W-1:0] status;

  modport source(output valid, read_data, length, status, input ready);
  modport sink(input valid, read_data, length, status, output ready);
endinterface

@@ sv/gap_buffer_edit_store.sv @@
// Gap buffer edit store: a byte sequence of up to CAPACITY items held in one
// synchronous RAM with a single gap. Each cmd word is one operation (read at
// index, insert one item, delete a range, clear); each gives one rsp word with
// read data, length after the operation and a status (ok, full, out of range).
// cmd.ready is high only while no operation is in progress and rst is low; one
// operation is worked on at a time. The response sits in an output register, so
// the next command is accepted while a result still waits on rsp.
// Reads wait on the RAM; rejected ops, a delete of zero and clear do not move
// the gap; insert and delete move it by d, the gap travel distance.
// Gap movement copies one entry per cycle through the RAM (read, then write
// in the next cycle), so d sets the cost of edits far from the last edit point.
// Result appears in the same cycle the block is ready again, unless rsp stalls:
// then the block holds the finished result internally until the register frees.
// Reset (rst, synchronous) empties the buffer and drops any pending response;
// RAM contents are not cleared and need no clearing pass.
// Depends on gbes_pkg, gbes_cmd_if, gbes_rsp_if.
module gap_buffer_edit_store #(
  parameter int CAPACITY  = gbes_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = gbes_pkg::ITEM_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  gbes_cmd_if.sink   cmd,
  gbes_rsp_if.source rsp
);
  import gbes_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int CW     = (PTR_W > POS_W + 1) ? PTR_W : POS_W + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_MOVE   = 6'b000100,
    S_APPLY  = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // gap and content pointers
  logic [PTR_W-1:0] gap_start, gap_end, content_length, dest;

  // latched command
  op_t                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [ITEM_BITS-1:0] item_q;
  logic [CNT_W-1:0]   cnt_q;

  // result staging and output register
  status_t             res_status;
  logic [RDATA_W-1:0]  res_rdata;
  logic                out_valid;
  logic [RDATA_W-1:0]  out_rdata;
  logic [LEN_W-1:0]    out_length;
  status_t             out_status;

  // RAM
  logic [ITEM_BITS-1:0] mem [CAPACITY];
  logic [ITEM_BITS-1:0] rd_q;
  logic                 mem_re, mem_we;
  logic [ADDR_W-1:0]    mem_raddr, mem_waddr;
  logic [ITEM_BITS-1:0] mem_wdata;
  logic                 wr_pend;
  logic [ADDR_W-1:0]    wr_addr;

  logic [CW-1:0] pos_w, end_w, len_w, phys_w;
  logic [PTR_W-1:0] gap_sz;
  logic out_free;

  assign cmd.ready     = (state == S_IDLE) && !rst;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rdata;
  assign rsp.length    = out_length;
  assign rsp.status    = out_status;

  assign out_free = !out_valid || rsp.ready;
  assign pos_w    = CW'(pos_q);
  assign end_w    = CW'(pos_q) + CW'(cnt_q);
  assign len_w    = CW'(content_length);
  assign gap_sz   = gap_end - gap_start;
  assign phys_w   = (pos_w < CW'(gap_start)) ? pos_w : pos_w + CW'(gap_sz);

  // RAM port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_EXEC) begin
      mem_re    = 1'b1;
      mem_raddr = phys_w[ADDR_W-1:0];
    end else if (state == S_MOVE) begin
      if (gap_start > dest) begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(gap_start - PTR_W'(1));
      end else if (gap_start < dest) begin
        mem_re    = 1'b1;
        mem_raddr = gap_end[ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    mem_we    = wr_pend;
    mem_waddr = wr_addr;
    mem_wdata = rd_q;
    if (state == S_APPLY && op_q == OP_INSERT) begin
      mem_we    = 1'b1;
      mem_waddr = gap_start[ADDR_W-1:0];
      mem_wdata = item_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.valid) state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        case (op_q)
          OP_READ:   if (pos_w < len_w) state_next = S_RDWAIT;
          OP_INSERT: if (pos_w <= len_w && content_length < PTR_W'(CAPACITY))
                       state_next = S_MOVE;
          OP_DELETE: if (cnt_q != '0 && end_w <= len_w) state_next = S_MOVE;
          default:   state_next = S_DONE;
        endcase
      end
      S_MOVE:   if (gap_start == dest) state_next = S_APPLY;
      S_APPLY:  state_next = S_DONE;
      S_RDWAIT: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gap_start      <= '0;
      gap_end        <= PTR_W'(CAPACITY);
      content_length <= '0;
      wr_pend        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= 1'b0;
      if (state == S_EXEC && op_q == OP_CLEAR) begin
        gap_start      <= '0;
        gap_end        <= PTR_W'(CAPACITY);
        content_length <= '0;
      end
      if (state == S_MOVE) begin
        if (gap_start > dest) begin
          gap_start <= gap_start - PTR_W'(1);
          gap_end   <= gap_end - PTR_W'(1);
          wr_pend   <= 1'b1;
        end else if (gap_start < dest) begin
          gap_start <= gap_start + PTR_W'(1);
          gap_end   <= gap_end + PTR_W'(1);
          wr_pend   <= 1'b1;
        end
      end
      if (state == S_APPLY) begin
        if (op_q == OP_INSERT) begin
          gap_start      <= gap_start + PTR_W'(1);
          content_length <= content_length + PTR_W'(1);
        end else begin
          gap_start      <= gap_start - PTR_W'(cnt_q);
          content_length <= content_length - PTR_W'(cnt_q);
        end
      end
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      op_q   <= op_t'(cmd.op);
      pos_q  <= cmd.position;
      item_q <= ITEM_BITS'(cmd.item);
      cnt_q  <= cmd.count;
    end
    // write the pending copy to the slot the gap just vacated
    if (state == S_MOVE) begin
      if (gap_start > dest) wr_addr <= ADDR_W'(gap_end - PTR_W'(1));
      else wr_addr <= gap_start[ADDR_W-1:0];
    end
    if (state == S_EXEC) begin
      res_rdata  <= '0;
      res_status <= ST_OK;
      case (op_q)
        OP_READ:   if (pos_w >= len_w) res_status <= ST_RANGE;
        OP_INSERT: begin
          if (pos_w > len_w) res_status <= ST_RANGE;
          else if (content_length >= PTR_W'(CAPACITY)) res_status <= ST_FULL;
          dest <= PTR_W'(pos_q);
        end
        OP_DELETE: begin
          if (cnt_q != '0 && end_w > len_w) res_status <= ST_RANGE;
          dest <= PTR_W'(end_w);
        end
        default: res_status <= ST_OK;
      endcase
    end
    if (state == S_RDWAIT) res_rdata <= RDATA_W'(rd_q);
    if (state == S_DONE && out_free) begin
      out_rdata  <= res_rdata;
      out_length <= LEN_W'(content_length);
      out_status <= res_status;
    end
  end

endmodule

@@ sv/gbes_checker.sv @@
// Port-level checks for the gap buffer edit store, bound to its top level.
// Depends on gbes_pkg and gap_buffer_edit_store_macros.svh.
`include "gap_buffer_edit_store_macros.svh"

module gbes_checker #(
  parameter int CAPACITY = gbes_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [gbes_pkg::RDATA_W-1:0]  rsp_read_data,
  input logic [gbes_pkg::LEN_W-1:0]    rsp_length,
  input logic [gbes_pkg::STATUS_W-1:0] rsp_status
);
  import gbes_pkg::*;

  // a stalled response word holds
  `GBES_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_read_data, rsp_length, rsp_status}))
  // one operation at a time
  `GBES_ASSERT_NXT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready, !cmd_ready)
  // full is reported only with the buffer at capacity
  `GBES_ASSERT_IMP(a_full_len, clk, rst, rsp_valid && rsp_status == ST_FULL, rsp_length == LEN_W'(CAPACITY))
  // data only comes back on a successful operation
  `GBES_ASSERT_IMP(a_err_no_data, clk, rst, rsp_valid && rsp_status != ST_OK, rsp_read_data == '0)
  // reset drops any pending response
  `GBES_ASSERT_ALW(a_rst_clears, clk, $past(rst), !rsp_valid)

endmodule

bind gap_buffer_edit_store gbes_checker #(
  .CAPACITY(CAPACITY)
) u_gbes_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_read_data(rsp.read_data),
  .rsp_length   (rsp.length),
  .rsp_status   (rsp.status)
);

@@ tb/sv/tb_gap_buffer_edit_store.sv @@
`timescale 1ns / 1ps
// Testbench for gap_buffer_edit_store: a directed table, then random edits and a fill to capacity.
// Every rsp word is checked against a gap buffer shadow kept here or a typed table value.
// Depends on gbes_pkg, gbes_cmd_if, gbes_rsp_if and the block itself.
module tb_gap_buffer_edit_store;
  import gbes_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int QUIET_MAX  = 40000;
  localparam int TAIL_WAIT  = 40;
  localparam int PHASE_LEN  = 45;
  localparam int TABLE_ROWS = 25;

  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic [LEN_W-1:0]   length;
    status_t            status;
  } edit_result_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item;
    logic [CNT_W-1:0]  count;
    logic              typed;
    edit_result_t      want;
  } edit_row_t;

  logic clk = 1'b0;
  logic rst;

  gbes_cmd_if cmd ();
  gbes_rsp_if rsp ();

  gap_buffer_edit_store dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  // Rows with typed set are checked against their want value, the rest
  // against the shadow buffer.
  edit_row_t edit_table [TABLE_ROWS] = '{
    '{OP_READ,   11'd0,    8'h00, 11'd0,    1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_READ,   11'd2047, 8'hFF, 11'd2047, 1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_DELETE, 11'd2047, 8'h00, 11'd0,    1'b1, '{8'h00, 11'd0, ST_OK}},
    '{OP_DELETE, 11'd0,    8'h00, 11'd1,    1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_DELETE, 11'd2047, 8'h00, 11'd2047, 1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_INSERT, 11'd1,    8'h55, 11'd0,    1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_INSERT, 11'd2047, 8'hAA, 11'd2047, 1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_INSERT, 11'd0,    8'h00, 11'd0,    1'b1, '{8'h00, 11'd1, ST_OK}},
    '{OP_INSERT, 11'd1,    8'hFF, 11'd0,    1'b1, '{8'h00, 11'd2, ST_OK}},
    '{OP_INSERT, 11'd0,    8'hA5, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_INSERT, 11'd2,    8'h5A, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd0,    8'h00, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd1,    8'h00, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd2,    8'h00, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd3,    8'h00, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd4,    8'h00, 11'd0,    1'b1, '{8'h00, 11'd4, ST_RANGE}},
    '{OP_DELETE, 11'd1,    8'h00, 11'd2,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd1,    8'h00, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_INSERT, 11'd3,    8'h11, 11'd0,    1'b1, '{8'h00, 11'd2, ST_RANGE}},
    '{OP_INSERT, 11'd2,    8'h3C, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_DELETE, 11'd0,    8'h00, 11'd3,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_INSERT, 11'd0,    8'h81, 11'd0,    1'b0, '{8'h00, 11'd0, ST_OK}},
    '{OP_CLEAR,  11'd0,    8'h00, 11'd0,    1'b1, '{8'h00, 11'd0, ST_OK}},
    '{OP_READ,   11'd0,    8'h00, 11'd0,    1'b1, '{8'h00, 11'd0, ST_RANGE}},
    '{OP_CLEAR,  11'd5,    8'h00, 11'd9,    1'b1, '{8'h00, 11'd0, ST_OK}}
  };

  // Shadow gap buffer
  logic [ITEM_W-1:0] shadow_store [CAPACITY];
  int gap_lo   = 0;
  int gap_hi   = CAPACITY;
  int used_len = 0;

  edit_result_t pending_results [$];
  int mismatches   = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic void move_gap(int dest);
    while (gap_lo > dest && gap_lo > 0 && gap_hi > 0) begin
      gap_lo--;
      gap_hi--;
      shadow_store[gap_hi] = shadow_store[gap_lo];
    end
    while (gap_lo < dest && gap_hi < CAPACITY) begin
      shadow_store[gap_lo] = shadow_store[gap_hi];
      gap_lo++;
      gap_hi++;
    end
  endfunction

  function automatic edit_result_t predict_edit(op_t op, int pos, logic [ITEM_W-1:0] itm,
                                                int cnt);
    edit_result_t res;
    int phys;
    res = '{read_data: '0, length: '0, status: ST_OK};
    case (op)
      OP_READ: begin
        if (pos < used_len) begin
          phys = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
          if (phys < CAPACITY) res.read_data = shadow_store[phys];
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_INSERT: begin
        // range check wins over full
        if (pos > used_len) begin
          res.status = ST_RANGE;
        end else if (used_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          move_gap(pos);
          if (gap_lo < gap_hi && gap_lo < CAPACITY) begin
            shadow_store[gap_lo] = itm;
            gap_lo++;
            used_len++;
          end
        end
      end
      OP_DELETE: begin
        if (cnt != 0) begin
          if (pos + cnt > used_len) begin
            res.status = ST_RANGE;
          end else begin
            move_gap(pos + cnt);
            gap_lo -= cnt;
            used_len -= cnt;
          end
        end
      end
      default: begin
        gap_lo = 0;
        gap_hi = CAPACITY;
        used_len = 0;
      end
    endcase
    res.length = used_len[LEN_W-1:0];
    return res;
  endfunction

  task automatic send_edit(op_t op, int pos, int itm, int cnt, bit typed = 1'b0,
                           edit_result_t want = '0);
    int idle;
    edit_result_t predicted;
    idle = 0;
    while ($urandom_range(0, 99) < src_idle_pct) idle++;
    if (idle > 0) begin
      cmd.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.op       <= op;
    cmd.position <= pos[POS_W-1:0];
    cmd.item     <= itm[ITEM_W-1:0];
    cmd.count    <= cnt[CNT_W-1:0];
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predicted = predict_edit(op, int'(pos[POS_W-1:0]), itm[ITEM_W-1:0], int'(cnt[CNT_W-1:0]));
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic int near_cursor(int spread);
    int p;
    p = gap_lo + int'($urandom_range(0, 2 * spread)) - spread;
    if (p < 0) p = 0;
    if (p > used_len) p = used_len;
    return p;
  endfunction

  task automatic random_edit();
    int r, p, c;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: any op, any field value
      send_edit(op_t'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom_range(0, 255),
                $urandom_range(0, 2047));
    end else if (r < 10) begin
      send_edit(OP_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 255),
                $urandom_range(0, 2047));
    end else if (r < 38) begin
      p = (used_len > 0) ? $urandom_range(0, used_len - 1) : 0;
      if ($urandom_range(0, 9) == 0) p = used_len;
      send_edit(OP_READ, p, $urandom_range(0, 255), $urandom_range(0, 15));
    end else if (r < 78 && used_len < 300) begin
      p = ($urandom_range(0, 9) < 6) ? near_cursor(3) : $urandom_range(0, used_len);
      if ($urandom_range(0, 11) == 0) p = used_len + 1;
      send_edit(OP_INSERT, p, $urandom_range(0, 255), $urandom_range(0, 7));
    end else begin
      c = $urandom_range(0, (used_len < 5) ? used_len : 5);
      if ($urandom_range(0, 9) == 0) c++;
      if (c <= used_len) begin
        p = ($urandom_range(0, 1) == 0) ? near_cursor(2) : $urandom_range(0, used_len - c);
        if (p > used_len - c) p = used_len - c;
      end else begin
        p = 0;
      end
      if ($urandom_range(0, 11) == 0) p++;
      send_edit(OP_DELETE, p, $urandom_range(0, 255), c);
    end
  endtask

  // Inserts near the cursor until full, then probes the full and boundary cases.
  task automatic fill_to_capacity();
    while (used_len < CAPACITY)
      send_edit(OP_INSERT, near_cursor(2), $urandom_range(0, 255), 0);
    send_edit(OP_INSERT, CAPACITY, 8'h5A, 0);
    send_edit(OP_INSERT, 0, 8'hA5, 0);
    send_edit(OP_INSERT, CAPACITY + 1, 8'h00, 0);
    send_edit(OP_INSERT, 2047, 8'hFF, 0);
    send_edit(OP_READ, CAPACITY - 1, 0, 0);
    send_edit(OP_READ, 0, 0, 0);
    send_edit(OP_READ, CAPACITY, 0, 0);
    send_edit(OP_DELETE, 5, 0, 0);
    send_edit(OP_DELETE, 1, 0, CAPACITY);
    send_edit(OP_DELETE, CAPACITY - 1, 0, 1);
    send_edit(OP_INSERT, CAPACITY - 1, 8'hC3, 0);
    send_edit(OP_INSERT, CAPACITY - 1, 8'h3C, 0);
    send_edit(OP_READ, CAPACITY - 1, 0, 0);
    send_edit(OP_DELETE, 0, 0, CAPACITY);
    send_edit(OP_READ, 0, 0, 0);
  endtask

  // Response side: random stalls, check against the oldest expectation.
  initial begin
    edit_result_t exp_word;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected rsp word data=%0h length=%0d status=%0d", $time,
                   rsp.read_data, rsp.length, rsp.status);
          mismatches++;
        end else begin
          exp_word = pending_results.pop_front();
          if (rsp.read_data !== exp_word.read_data) begin
            $display("%0t: read_data expected %0h actual %0h", $time, exp_word.read_data,
                     rsp.read_data);
            mismatches++;
          end
          if (rsp.length !== exp_word.length) begin
            $display("%0t: length expected %0d actual %0d", $time, exp_word.length,
                     rsp.length);
            mismatches++;
          end
          if (rsp.status !== exp_word.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_word.status,
                     rsp.status);
            mismatches++;
          end
        end
      end
      rsp.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    cmd.valid    <= 1'b0;
    cmd.op       <= OP_READ;
    cmd.position <= '0;
    cmd.item     <= '0;
    cmd.count    <= '0;
    src_idle_pct = 16;
    dst_idle_pct = 79;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (edit_table[i])
      send_edit(edit_table[i].op, edit_table[i].position, edit_table[i].item,
                edit_table[i].count, edit_table[i].typed, edit_table[i].want);

    repeat (PHASE_LEN) random_edit();
    src_idle_pct = 79;
    dst_idle_pct = 16;
    repeat (PHASE_LEN) random_edit();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    repeat (PHASE_LEN) random_edit();
    fill_to_capacity();
    cmd.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ gap_buffer_edit_store.f @@
+incdir+sv
sv/gbes_pkg.sv
sv/gbes_cmd_if.sv
sv/gbes_rsp_if.sv
sv/gap_buffer_edit_store.sv
sv/gbes_checker.sv
tb/sv/tb_gap_buffer_edit_store.sv
